// ----- hw/rtl/bfra_pkg.sv -----
// ----------------------------------------------------------------------------
// bfra_pkg
// Shared codes, widths and cell control types for the best-fit allocator.
// ----------------------------------------------------------------------------
package bfra_pkg;

	localparam int ID_W   = 16;
	localparam int SIZE_W = 16;
	localparam int TIME_W = 24;
	localparam int CFG_W  = 16;
	localparam int STS_W  = 3;
	localparam int OUT_W  = 16;

	localparam logic [CFG_W-1:0] CFG_RESET = 16'hFFFF;

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_FREE    = 2'd1,
		CMD_TICK    = 2'd2,
		CMD_COMPACT = 2'd3
	} cmd_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK      = 3'd0,
		STS_DUP     = 3'd1,
		STS_NOFIT   = 3'd2,
		STS_UNKNOWN = 3'd3,
		STS_FULL    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_SHIFT,
		CELL_LOAD,
		CELL_SORT,
		CELL_CLEAR
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t mode;
		logic       phase;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_DECIDE,
		FSM_LOAD,
		FSM_SORT,
		FSM_REPLY
	} fsm_t;

endpackage

// ----- hw/rtl/bfra_if.sv -----
// ----------------------------------------------------------------------------
// bfra_if
// Request and response channels of the allocator, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bfra_req_if import bfra_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        command;
	logic [ID_W-1:0]   task_id;
	logic [SIZE_W-1:0] region_size;
	logic [TIME_W-1:0] lifetime;
	logic [TIME_W-1:0] elapsed;

	modport source (
		output valid, command, task_id, region_size, lifetime, elapsed,
		input  ready
	);
	modport sink (
		input  valid, command, task_id, region_size, lifetime, elapsed,
		output ready
	);
endinterface

interface bfra_rsp_if import bfra_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [STS_W-1:0] status;
	logic [OUT_W-1:0] base_address;
	logic [OUT_W-1:0] free_words;
	logic             any_live;

	modport source (
		output valid, status, base_address, free_words, any_live,
		input  ready
	);
	modport sink (
		input  valid, status, base_address, free_words, any_live,
		output ready
	);
endinterface

// ----- hw/rtl/best_fit_region_allocator.sv -----
// ----------------------------------------------------------------------------
// best_fit_region_allocator
// Best-fit region allocator over a linear memory, tasks held in a cell chain.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command word (allocate, free, advance time, compact);
//   rsp returns one word per command: status, base, free total, live flag.
//   cfg_we/cfg_wdata set the memory size; only write while no command is
//   in flight. A write drops every allocation and leaves one free hole.
// Timing:
//   Tasks sit in a chain of MAX_TASKS cells kept in base address order.
//   Every command rotates the chain once past the head,
//   where gaps, owner match and timers are handled one slot per cycle.
//   A successful allocate, a successful free and advance time then run
//   MAX_TASKS odd-even exchange steps to restore the order.
//   One command at a time; req.ready is high only between commands.
// Reset: no tasks, memory size 65535, one hole over the whole memory.
// Stall: the response is held in a register; the next command is taken
//   while it waits, but its own response waits until rsp.ready.
// ----------------------------------------------------------------------------
module best_fit_region_allocator import bfra_pkg::*; #(
	parameter int MAX_TASKS = 32,
	parameter int ADDR_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	bfra_req_if.sink         req,
	bfra_rsp_if.source       rsp
);

	localparam int EntryW = 1 + ID_W + 2 * ADDR_BITS + TIME_W;
	localparam int CntW   = $clog2(MAX_TASKS + 1);
	localparam int CW     = (ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W;

	typedef struct packed {
		logic                 valid;
		logic [ID_W-1:0]      owner;
		logic [ADDR_BITS-1:0] base;
		logic [ADDR_BITS-1:0] length;
		logic [TIME_W-1:0]    remaining;
	} entry_t;

	fsm_t                 state_q, state_d;
	cell_ctrl_t           cell_ctrl;
	logic [CntW-1:0]      cnt_q;
	logic                 cnt_last;
	logic                 rsp_valid_q;
	logic [ADDR_BITS-1:0] mem_q;
	logic [ADDR_BITS-1:0] free_q;

	cmd_t                 cmd_q;
	logic [ID_W-1:0]      id_q;
	logic [SIZE_W-1:0]    size_q;
	logic [TIME_W-1:0]    life_q;
	logic [TIME_W-1:0]    elapsed_q;
	logic [ADDR_BITS-1:0] cursor_q;
	logic                 best_ok_q;
	logic [ADDR_BITS-1:0] best_len_q;
	logic [ADDR_BITS-1:0] best_base_q;
	logic                 dup_q;
	logic                 found_q;
	logic [CntW-1:0]      live_cnt_q;
	status_t              status_q;
	logic [ADDR_BITS-1:0] base_q;

	logic [STS_W-1:0]     rsp_status_q;
	logic [OUT_W-1:0]     rsp_base_q;
	logic [OUT_W-1:0]     rsp_free_q;
	logic                 rsp_live_q;

	logic [EntryW-1:0]    cell_val [MAX_TASKS];
	logic [EntryW-1:0]    lt_w     [MAX_TASKS];
	logic [EntryW-1:0]    rt_w     [MAX_TASKS];
	logic [MAX_TASKS-1:0] vld;

	entry_t               head, feed, new_entry;
	logic [ADDR_BITS-1:0] gap, fin_gap, add_len;
	logic                 gap_take, fin_take, owner_hit, expired;
	logic                 accept, send;
	status_t              status_d;

	// ---------------------------------------------------------------- chain
	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign lt_w[i] = cell_val[i];
		end else begin : g_mid_l
			assign lt_w[i] = cell_val[i-1];
		end
		if (i == MAX_TASKS - 1) begin : g_last
			assign rt_w[i] = feed;
		end else begin : g_mid_r
			assign rt_w[i] = cell_val[i+1];
		end
		assign vld[i] = cell_val[i][EntryW-1];

		bfra_cell #(
			.ADDR_BITS (ADDR_BITS),
			.IDX       (i),
			.CELLS     (MAX_TASKS)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctrl  (cell_ctrl),
			.left  (lt_w[i]),
			.right (rt_w[i]),
			.value (cell_val[i])
		);
	end

	// ------------------------------------------------------- head datapath
	assign head      = entry_t'(cell_val[0]);
	assign gap       = head.base - cursor_q;
	assign gap_take  = head.valid && (CW'(gap) >= CW'(size_q)) &&
	                   (!best_ok_q || (gap < best_len_q));
	assign owner_hit = head.valid && (head.owner == id_q);
	assign expired   = elapsed_q >= head.remaining;
	assign fin_gap   = mem_q - cursor_q;
	assign fin_take  = (mem_q > cursor_q) && (CW'(fin_gap) >= CW'(size_q)) &&
	                   (!best_ok_q || (fin_gap < best_len_q));
	assign cnt_last  = cnt_q == CntW'(MAX_TASKS - 1);
	assign accept    = req.valid && req.ready;
	assign send      = !rsp_valid_q || rsp.ready;

	always_comb begin
		new_entry.valid     = 1'b1;
		new_entry.owner     = id_q;
		new_entry.base      = best_base_q;
		new_entry.length    = ADDR_BITS'(size_q);
		new_entry.remaining = life_q;
	end

	// word fed into the tail: the rotated head, or the new entry on load
	always_comb begin
		feed    = head;
		add_len = '0;
		if (state_q == FSM_LOAD) begin
			feed = new_entry;
		end else if (head.valid) begin
			case (cmd_q)
				CMD_FREE: begin
					if (owner_hit) begin
						feed.valid = 1'b0;
						add_len    = head.length;
					end
				end
				CMD_TICK: begin
					if (expired) begin
						feed.valid = 1'b0;
						add_len    = head.length;
					end else begin
						feed.remaining = head.remaining - elapsed_q;
					end
				end
				CMD_COMPACT: feed.base = cursor_q;
				default: feed = head;
			endcase
		end
	end

	always_comb begin
		if (cmd_q == CMD_FREE) begin
			status_d = found_q ? STS_OK : STS_UNKNOWN;
		end else if (cmd_q != CMD_ALLOC) begin
			status_d = STS_OK;
		end else if (dup_q) begin
			status_d = STS_DUP;
		end else if ((size_q == '0) || !(best_ok_q || fin_take)) begin
			status_d = STS_NOFIT;
		end else if (live_cnt_q == CntW'(MAX_TASKS)) begin
			status_d = STS_FULL;
		end else begin
			status_d = STS_OK;
		end
	end

	// ------------------------------------------------------------------ fsm
	always_comb begin
		state_d         = state_q;
		cell_ctrl.mode  = CELL_HOLD;
		cell_ctrl.phase = cnt_q[0];
		unique case (state_q)
			FSM_IDLE: begin
				if (cfg_we) cell_ctrl.mode = CELL_CLEAR;
				if (accept) state_d = FSM_SCAN;
			end
			FSM_SCAN: begin
				cell_ctrl.mode = CELL_SHIFT;
				if (cnt_last) state_d = FSM_DECIDE;
			end
			FSM_DECIDE: begin
				if (status_d == STS_OK && cmd_q == CMD_ALLOC) begin
					state_d = FSM_LOAD;
				end else if ((cmd_q == CMD_FREE && found_q) || cmd_q == CMD_TICK) begin
					state_d = FSM_SORT;
				end else begin
					state_d = FSM_REPLY;
				end
			end
			FSM_LOAD: begin
				cell_ctrl.mode = CELL_LOAD;
				state_d        = FSM_SORT;
			end
			FSM_SORT: begin
				cell_ctrl.mode = CELL_SORT;
				if (cnt_last) state_d = FSM_REPLY;
			end
			FSM_REPLY: begin
				if (send) state_d = FSM_IDLE;
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	assign req.ready = state_q == FSM_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			mem_q       <= ADDR_BITS'(CFG_RESET);
			free_q      <= ADDR_BITS'(CFG_RESET);
		end else begin
			state_q <= state_d;
			if ((state_q == FSM_SCAN || state_q == FSM_SORT) && !cnt_last) begin
				cnt_q <= cnt_q + CntW'(1);
			end else begin
				cnt_q <= '0;
			end
			if (state_q == FSM_REPLY && send) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == FSM_IDLE && cfg_we) begin
				mem_q  <= ADDR_BITS'(cfg_wdata);
				free_q <= ADDR_BITS'(cfg_wdata);
			end else if (state_q == FSM_SCAN) begin
				free_q <= free_q + add_len;
			end else if (state_q == FSM_LOAD) begin
				free_q <= free_q - ADDR_BITS'(size_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= cmd_t'(req.command);
			id_q       <= req.task_id;
			size_q     <= req.region_size;
			life_q     <= req.lifetime;
			elapsed_q  <= req.elapsed;
			cursor_q   <= '0;
			best_ok_q  <= 1'b0;
			dup_q      <= 1'b0;
			found_q    <= 1'b0;
			live_cnt_q <= '0;
		end
		if (state_q == FSM_SCAN && head.valid) begin
			live_cnt_q <= live_cnt_q + CntW'(1);
			if (owner_hit) begin
				dup_q   <= 1'b1;
				found_q <= 1'b1;
			end
			if (cmd_q == CMD_ALLOC) begin
				cursor_q <= head.base + head.length;
				if (gap_take) begin
					best_ok_q   <= 1'b1;
					best_len_q  <= gap;
					best_base_q <= cursor_q;
				end
			end else if (cmd_q == CMD_COMPACT) begin
				cursor_q <= cursor_q + head.length;
			end
		end
		if (state_q == FSM_DECIDE) begin
			status_q <= status_d;
			base_q   <= '0;
			if (cmd_q == CMD_ALLOC && status_d == STS_OK) begin
				if (fin_take) begin
					// the top hole wins
					best_base_q <= cursor_q;
					base_q      <= cursor_q;
				end else begin
					base_q <= best_base_q;
				end
			end
		end
		if (state_q == FSM_REPLY && send) begin
			rsp_status_q <= status_q;
			rsp_base_q   <= OUT_W'(base_q);
			rsp_free_q   <= OUT_W'(free_q);
			rsp_live_q   <= |vld;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.base_address = rsp_base_q;
	assign rsp.free_words   = rsp_free_q;
	assign rsp.any_live     = rsp_live_q;

`ifndef SYNTHESIS
	a_free_le_mem: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= mem_q)
		else $error("free total above memory size");

	a_chain_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_IDLE) |-> (((vld + MAX_TASKS'(1)) & vld) == '0))
		else $error("live slots not packed at the head between commands");

	a_rsp_from_reply: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == FSM_REPLY))
		else $error("response raised outside reply");

	a_alloc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_LOAD) |->
		((CW + 1)'(best_base_q) + (CW + 1)'(size_q) <= (CW + 1)'(mem_q)))
		else $error("allocated region runs past memory end");
`endif

endmodule

// ----- hw/rtl/bfra_cell.sv -----
// ----------------------------------------------------------------------------
// bfra_cell
// One slot of the task chain: shifts towards the head, or takes part in an
// odd-even exchange with a neighbour to keep slots ordered by base address.
// ----------------------------------------------------------------------------
module bfra_cell import bfra_pkg::*; #(
	parameter int ADDR_BITS = 16,
	parameter int IDX       = 0,
	parameter int CELLS     = 2,
	localparam int EntryW   = 1 + ID_W + 2 * ADDR_BITS + TIME_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctrl_t        ctrl,
	input  logic [EntryW-1:0] left,
	input  logic [EntryW-1:0] right,
	output logic [EntryW-1:0] value
);

	localparam bit IsFirst = (IDX == 0);
	localparam bit IsLast  = (IDX == CELLS - 1);
	localparam bit Parity  = (IDX % 2) == 1;

	typedef struct packed {
		logic                 valid;
		logic [ID_W-1:0]      owner;
		logic [ADDR_BITS-1:0] base;
		logic [ADDR_BITS-1:0] length;
		logic [TIME_W-1:0]    remaining;
	} entry_t;

	logic              valid_q;
	logic [EntryW-2:0] data_q;
	entry_t            cur, lt, rt, nxt;

	// empty slots sort after every live one; their base is never looked at
	function automatic logic [ADDR_BITS:0] sort_key(input entry_t e);
		sort_key = e.valid ? {1'b0, e.base} : {1'b1, {ADDR_BITS{1'b0}}};
	endfunction

	assign cur   = entry_t'({valid_q, data_q});
	assign lt    = entry_t'(left);
	assign rt    = entry_t'(right);
	assign value = cur;

	always_comb begin
		nxt = cur;
		unique case (ctrl.mode)
			CELL_SHIFT: nxt = rt;
			CELL_LOAD: begin
				if (IsLast) nxt = rt;
			end
			CELL_SORT: begin
				if ((ctrl.phase == Parity) && !IsLast) begin
					if (sort_key(rt) < sort_key(cur)) nxt = rt;
				end else if ((ctrl.phase != Parity) && !IsFirst) begin
					if (sort_key(cur) < sort_key(lt)) nxt = lt;
				end
			end
			CELL_CLEAR: nxt.valid = 1'b0;
			default: nxt = cur;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt[EntryW-2:0];
	end

endmodule
